@@ design/abre_pkg.sv @@
`timescale 1ns / 1ps

package abre_pkg;

    localparam int IDX_W  = 12;
    localparam int SIZE_W = 13;
    localparam int WORD_W = 64;
    localparam int SIZE_RESET = 4096;

    typedef enum logic [1:0] {
        FN_MARK_BUSY  = 2'd0,
        FN_MARK_FREE  = 2'd1,
        FN_QUERY_FREE = 2'd2,
        FN_FIND_BUSY  = 2'd3
    } t_func;

    typedef struct packed {
        t_func             func;
        logic [IDX_W-1:0]  first_index;
        logic [IDX_W-1:0]  last_index;
    } t_in;

    typedef struct packed {
        logic              status;
        logic              range_free;
        logic [SIZE_W-1:0] found_position;
    } t_out;

    // request travelling down the row of word cells
    typedef struct packed {
        logic              vld;
        t_func             func;
        logic [IDX_W-1:0]  first;
        logic [IDX_W-1:0]  last;
        logic              any;
        logic              found;
        logic [SIZE_W-1:0] pos;
    } t_tok;

endpackage

@@ design/abre_cell.sv @@
`timescale 1ns / 1ps

module abre_cell
    import abre_pkg::*;
#(
    parameter int P_IDX = 0
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_clr,
    input  t_tok i_tok,
    output t_tok o_tok
);

    logic [WORD_W-1:0] r_word;
    logic [WORD_W-1:0] n_word;
    t_tok              r_tok;
    t_tok              n_tok;

    logic [31:0]       w_sw;
    logic [31:0]       w_ew;
    logic [31:0]       w_me;
    logic [5:0]        w_lo;
    logic [5:0]        w_hi;
    logic [WORD_W-1:0] w_rmask;
    logic [WORD_W-1:0] w_fmask;
    logic [WORD_W-1:0] w_hits;
    logic [5:0]        w_lb;

    // lowest set bit of the masked word
    function automatic logic [5:0] low_bit(input logic [WORD_W-1:0] w);
        logic [5:0] n;
        n = 6'd0;
        for (int k = WORD_W - 1; k >= 0; k--) begin
            if (w[k]) begin
                n = 6'(k);
            end
        end
        return n;
    endfunction

    assign w_sw = 32'(i_tok.first[IDX_W-1:6]);
    assign w_ew = 32'(i_tok.last[IDX_W-1:6]);
    assign w_me = 32'(P_IDX);
    assign w_lo = (w_me == w_sw) ? i_tok.first[5:0] : 6'd0;
    assign w_hi = (w_me == w_ew) ? i_tok.last[5:0] : 6'd63;

    always_comb begin
        w_rmask = '0;
        if (w_me >= w_sw && w_me <= w_ew) begin
            w_rmask = ({WORD_W{1'b1}} << w_lo) & ({WORD_W{1'b1}} >> (6'd63 - w_hi));
        end
        if (w_me < w_sw) begin
            w_fmask = '0;
        end else if (w_me == w_sw) begin
            w_fmask = {WORD_W{1'b1}} << i_tok.first[5:0];
        end else begin
            w_fmask = {WORD_W{1'b1}};
        end
    end

    assign w_hits = r_word & w_fmask;
    assign w_lb   = low_bit(w_hits);

    always_comb begin
        n_word = r_word;
        n_tok  = i_tok;
        if (i_tok.vld) begin
            case (i_tok.func)
                FN_MARK_BUSY:  n_word = r_word | w_rmask;
                FN_MARK_FREE:  n_word = r_word & ~w_rmask;
                FN_QUERY_FREE: n_tok.any = i_tok.any | (|(r_word & w_rmask));
                FN_FIND_BUSY: begin
                    if (!i_tok.found && (|w_hits)) begin
                        n_tok.found = 1'b1;
                        n_tok.pos   = 13'(P_IDX * WORD_W) + {7'd0, w_lb};
                    end
                end
                default: n_word = r_word;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word    <= '0;
            r_tok.vld <= 1'b0;
        end else begin
            r_word <= i_clr ? '0 : n_word;
            r_tok  <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule

@@ design/allocation_bitmap_range_engine_top.sv @@
`timescale 1ns / 1ps

// allocation bitmap with range mark, range query and find-next-busy
//
// input channel : i_valid / o_ready carrying i_data (func, first_index, last_index)
// output channel: o_valid / i_ready carrying o_data (status, range_free,
//                 found_position), exactly one transfer out per transfer in
// config        : i_cfg_we with i_cfg_wdata writes size_in_use (clamped to
//                 MAX_BITS) and clears the whole bitmap in the same cycle
//
// the bitmap lives in a row of (MAX_BITS+63)/64 cells, one 64-bit word each;
// a request walks the row one cell per cycle, from the injection register through
// every cell in turn to the output register, the same walk whatever its range;
// a rejected request (reversed range on a mark or query, index beyond size,
// size zero) goes straight to the output register, or the skid, without the row
// one request is in flight at a time, and no new transfer is taken until it has
// left the row, the state staying busy meanwhile; o_ready rises again once the
// result sits in the output register, so a new transfer can start while the
// receiver still holds off the previous result
// when the receiver stalls the result waits in the output register, a
// second finished result waits in a skid register and o_ready stays low
// reset clears every word (all units free) and sets size to min(4096, MAX_BITS)
module allocation_bitmap_range_engine_top
    import abre_pkg::*;
#(
    parameter int MAX_BITS = 4096
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  t_in               i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output t_out              o_data,
    input  logic              i_cfg_we,
    input  logic [SIZE_W-1:0] i_cfg_wdata
);

    localparam int NCELLS   = (MAX_BITS + WORD_W - 1) / WORD_W;
    localparam int SIZE_RST = (MAX_BITS < SIZE_RESET) ? MAX_BITS : SIZE_RESET;

    typedef enum logic {
        S_IDLE,
        S_BUSY
    } t_state;

    t_state            r_state;
    logic [SIZE_W-1:0] r_size;
    t_tok              r_inj;
    logic              r_out_vld;
    t_out              r_out;
    logic              r_skid_vld;
    t_out              r_skid;

    t_tok              w_tok [NCELLS+1];
    t_tok              w_exit;
    logic              w_accept;
    logic              w_err;
    logic              w_done;
    t_out              w_res;
    logic              w_take;

    // row of word cells, request enters at cell zero
    assign w_tok[0] = r_inj;

    for (genvar g = 0; g < NCELLS; g++) begin : g_cell
        abre_cell #(
            .P_IDX(g)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_clr  (i_cfg_we),
            .i_tok  (w_tok[g]),
            .o_tok  (w_tok[g+1])
        );
    end

    assign w_exit = w_tok[NCELLS];

    // no new transfer while one is in the row or a result waits in the skid
    assign o_ready  = (r_state == S_IDLE) && !r_skid_vld;
    assign w_accept = i_valid && o_ready;
    assign w_take   = r_out_vld && i_ready;

    // range and size checks happen at the input, the row only sees good requests
    always_comb begin
        if (i_data.func == FN_FIND_BUSY) begin
            w_err = ({1'b0, i_data.first_index} >= r_size);
        end else begin
            w_err = (i_data.first_index > i_data.last_index) ||
                    ({1'b0, i_data.last_index} >= r_size);
        end
    end

    // result comes either from a rejected request or from the end of the row
    always_comb begin
        w_res = '0;
        w_done = 1'b0;
        if (w_accept && w_err) begin
            w_done     = 1'b1;
            w_res.status = 1'b1;
        end else if (w_exit.vld) begin
            w_done = 1'b1;
            if (w_exit.func == FN_QUERY_FREE) begin
                w_res.range_free = !w_exit.any;
            end
            if (w_exit.func == FN_FIND_BUSY) begin
                // nothing busy up to the end of the row: answer is the size
                w_res.found_position = w_exit.found ? w_exit.pos : r_size;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_size     <= 13'(SIZE_RST);
            r_inj.vld  <= 1'b0;
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                // size above capacity saturates
                r_size <= (32'(i_cfg_wdata) > 32'(MAX_BITS)) ? 13'(MAX_BITS) : i_cfg_wdata;
            end

            case (r_state)
                S_IDLE: begin
                    r_inj.vld <= w_accept && !w_err;
                    if (w_accept && !w_err) begin
                        r_inj.func  <= i_data.func;
                        r_inj.first <= i_data.first_index;
                        r_inj.last  <= i_data.last_index;
                        r_inj.any   <= 1'b0;
                        r_inj.found <= 1'b0;
                        r_inj.pos   <= '0;
                        r_state     <= S_BUSY;
                    end
                end
                S_BUSY: begin
                    r_inj.vld <= 1'b0;
                    if (w_exit.vld) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_inj.vld <= 1'b0;
                    r_state   <= S_IDLE;
                end
            endcase

            // output register with one skid entry behind it
            if (w_done) begin
                if (!r_out_vld || w_take) begin
                    r_out     <= w_res;
                    r_out_vld <= 1'b1;
                end else begin
                    r_skid     <= w_res;
                    r_skid_vld <= 1'b1;
                end
            end else if (w_take) begin
                if (r_skid_vld) begin
                    r_out      <= r_skid;
                    r_skid_vld <= 1'b0;
                end else begin
                    r_out_vld <= 1'b0;
                end
            end
        end
    end

    assign o_valid = r_out_vld;
    assign o_data  = r_out;

    // the skid only fills while a result is already waiting at the output
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid holds a result with the output register empty");

    // while a request walks the row the skid is empty, so its result has a place
    a_busy_skid_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BUSY) |-> !r_skid_vld)
        else $error("skid occupied during a row walk");

    // a request only leaves the row while one is in flight
    a_exit_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_exit.vld |-> (r_state == S_BUSY))
        else $error("request left the row with none in flight");

    // after a rejected request the output register holds a result in the next cycle
    a_err_answers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_err) |=> (r_out_vld && (r_state == S_IDLE)))
        else $error("rejected request produced no result");

    // a request entering the row leaves the state busy
    a_inject_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inj.vld |-> (r_state == S_BUSY))
        else $error("request entered the row outside a walk");

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

// checks the allocation bitmap engine against a bit-level model of the busy map
module testbench;
    import abre_pkg::*;

    localparam int CAPACITY = 4096;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_ready;
    t_in               i_data;
    logic              o_valid;
    logic              i_ready;
    t_out              o_data;
    logic              i_cfg_we;
    logic [SIZE_W-1:0] i_cfg_wdata;

    allocation_bitmap_range_engine_top #(
        .MAX_BITS(CAPACITY)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_data     (i_data),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_data     (o_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // model of the block: one bit per unit, plus the size in use
    bit [CAPACITY-1:0] busy_map   = '0;
    logic [SIZE_W-1:0] model_size = SIZE_W'(SIZE_RESET);

    // answers still owed by the block, oldest first
    t_out pending_answers[$];
    int   errors        = 0;
    int   results_taken = 0;

    // a directed row carries a hand-typed answer when typed_en is set
    logic typed_en;
    t_out typed_result;

    // no idling on either side while this is set
    bit quiet_phase = 1'b0;

    typedef struct packed {
        logic              is_size_write;
        logic [SIZE_W-1:0] size_value;
        t_in               req;
        logic              typed;
        t_out              answer;
    } t_row;

    t_row directed_rows[$];

    // ---------------------------------------------------------------
    // model of one request: updates busy_map and returns the answer
    // ---------------------------------------------------------------
    function automatic t_out apply_request(input t_in req);
        t_out        r;
        int unsigned lo;
        int unsigned hi;
        int unsigned k;
        bit          hit;
        r   = '0;
        lo  = req.first_index;
        hi  = req.last_index;
        hit = 1'b0;
        if (req.func == FN_FIND_BUSY) begin
            if (model_size == 0 || lo >= model_size) begin
                r.status = 1'b1;
            end else begin
                // nothing busy from the start onwards answers with the size
                r.found_position = model_size;
                for (k = lo; k < model_size && !hit; k++) begin
                    if (busy_map[k]) begin
                        r.found_position = SIZE_W'(k);
                        hit = 1'b1;
                    end
                end
            end
        end else if (model_size == 0 || lo > hi || hi >= model_size) begin
            // reversed range or index beyond the size: error, map untouched
            r.status = 1'b1;
        end else begin
            r.range_free = (req.func == FN_QUERY_FREE);
            for (k = lo; k <= hi; k++) begin
                case (req.func)
                    FN_MARK_BUSY: busy_map[k] = 1'b1;
                    FN_MARK_FREE: busy_map[k] = 1'b0;
                    default: begin
                        if (busy_map[k]) r.range_free = 1'b0;
                    end
                endcase
            end
        end
        return r;
    endfunction

    // ---------------------------------------------------------------
    // checker: compares each result transfer with the oldest answer owed,
    // and runs the model on each request transfer and size write
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin : answer_check
        t_out want;
        t_out model_answer;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (pending_answers.size() == 0) begin
                    $display("%0t: unexpected result status %0d free %0d pos %0d",
                             $time, o_data.status, o_data.range_free,
                             o_data.found_position);
                    errors++;
                end else begin
                    want = pending_answers.pop_front();
                    if (o_data.status !== want.status ||
                        o_data.range_free !== want.range_free ||
                        o_data.found_position !== want.found_position) begin
                        $display("%0t: expected status %0d free %0d pos %0d, got %0d %0d %0d",
                                 $time, want.status, want.range_free,
                                 want.found_position, o_data.status,
                                 o_data.range_free, o_data.found_position);
                        errors++;
                    end
                end
                results_taken++;
            end
            if (i_valid && o_ready) begin
                model_answer = apply_request(i_data);
                pending_answers.push_back(typed_en ? typed_result : model_answer);
            end
            if (i_cfg_we) begin
                // a size write saturates at the capacity and frees every unit
                model_size = (i_cfg_wdata > CAPACITY) ? SIZE_W'(CAPACITY) : i_cfg_wdata;
                busy_map   = '0;
            end
        end
    end

    // ---------------------------------------------------------------
    // directed table
    // ---------------------------------------------------------------
    function automatic void add_size(input int v);
        t_row row;
        row               = '0;
        row.is_size_write = 1'b1;
        row.size_value    = SIZE_W'(v);
        directed_rows.push_back(row);
    endfunction

    // request whose answer comes from the model
    function automatic void add_req(input t_func f, input int first, input int last);
        t_row row;
        row                 = '0;
        row.req.func        = f;
        row.req.first_index = IDX_W'(first);
        row.req.last_index  = IDX_W'(last);
        directed_rows.push_back(row);
    endfunction

    // request with the answer typed in
    function automatic void add_chk(input t_func f, input int first, input int last,
                                    input bit st, input bit fr, input int pos);
        t_row row;
        row                      = '0;
        row.req.func             = f;
        row.req.first_index      = IDX_W'(first);
        row.req.last_index       = IDX_W'(last);
        row.typed                = 1'b1;
        row.answer.status        = st;
        row.answer.range_free    = fr;
        row.answer.found_position = SIZE_W'(pos);
        directed_rows.push_back(row);
    endfunction

    function automatic void build_directed_rows();
        // fresh map after reset: all free, search runs off the end
        add_chk(FN_FIND_BUSY,     0,    0, 0, 0, 4096);
        add_chk(FN_QUERY_FREE,    0, 4095, 0, 1, 0);
        add_chk(FN_MARK_BUSY,     0, 4095, 0, 0, 0);
        add_chk(FN_FIND_BUSY,  4095,    0, 0, 0, 4095);
        // one whole word freed, needs the all-ones mask
        add_chk(FN_MARK_FREE,    64,  127, 0, 0, 0);
        add_chk(FN_QUERY_FREE,   64,  127, 0, 1, 0);
        add_chk(FN_FIND_BUSY,    64,    0, 0, 0, 128);
        add_chk(FN_QUERY_FREE,   63,   64, 0, 0, 0);
        // reversed ranges
        add_chk(FN_MARK_BUSY,    10,    5, 1, 0, 0);
        add_chk(FN_QUERY_FREE, 4095,    0, 1, 0, 0);
        add_chk(FN_MARK_FREE,     0, 4095, 0, 0, 0);
        // single bit at the top
        add_chk(FN_MARK_BUSY,  4095, 4095, 0, 0, 0);
        add_chk(FN_FIND_BUSY,     0,    0, 0, 0, 4095);
        add_req(FN_MARK_BUSY,   130, 1000);
        add_req(FN_FIND_BUSY,     5, 4095);
        // small size: indices at the size are out of range
        add_size(100);
        add_chk(FN_MARK_BUSY,    50,  100, 1, 0, 0);
        add_chk(FN_FIND_BUSY,   100,    0, 1, 0, 0);
        add_chk(FN_FIND_BUSY,    99,    0, 0, 0, 100);
        add_chk(FN_MARK_BUSY,    99,   99, 0, 0, 0);
        add_chk(FN_QUERY_FREE,    0,   99, 0, 0, 0);
        // no array at all
        add_size(0);
        add_chk(FN_FIND_BUSY,     0,    0, 1, 0, 0);
        add_chk(FN_QUERY_FREE,    0,    0, 1, 0, 0);
        // size above capacity saturates
        add_size(8191);
        add_chk(FN_FIND_BUSY,  4095, 4095, 0, 0, 4096);
        add_chk(FN_MARK_FREE,  4095, 4095, 0, 0, 0);
    endfunction

    // ---------------------------------------------------------------
    // random requests
    // ---------------------------------------------------------------

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        if (quiet_phase) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 15);
        return $urandom_range(30, 90);
    endfunction

    // index inside the size most of the time, anywhere otherwise
    function automatic int unsigned pick_index(input int unsigned span);
        if (span == 0 || $urandom_range(0, 9) == 0) return $urandom_range(0, CAPACITY - 1);
        return $urandom_range(0, span - 1);
    endfunction

    function automatic t_in random_request(input int unsigned span);
        t_in         req;
        int          r;
        int unsigned first;
        int unsigned last;
        r        = $urandom_range(0, 99);
        req.func = (r < 35) ? FN_MARK_BUSY :
                   (r < 55) ? FN_MARK_FREE :
                   (r < 75) ? FN_QUERY_FREE : FN_FIND_BUSY;
        first = pick_index(span);
        r     = $urandom_range(0, 99);
        if (r < 60) begin
            // short range from the first index, last clipped to the size
            last = first + $urandom_range(0, 70);
            if (span != 0 && last >= span) last = span - 1;
        end else if (r < 90) begin
            last = pick_index(span);
        end else begin
            last = $urandom_range(0, CAPACITY - 1);
        end
        req.first_index = IDX_W'(first);
        req.last_index  = IDX_W'(last);
        return req;
    endfunction

    // ---------------------------------------------------------------
    // request side
    // ---------------------------------------------------------------
    int unsigned cur_size = CAPACITY;

    // offers one request and returns at the edge of its transfer;
    // valid stays high when the next request follows without a gap
    task automatic send_item(input t_in req, input logic typed, input t_out answer);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_data       <= req;
        typed_en     <= typed;
        typed_result <= answer;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // size writes only once the block has drained
    task automatic write_size(input logic [SIZE_W-1:0] v);
        i_valid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cur_size = (v > CAPACITY) ? CAPACITY : v;
    endtask

    initial begin : stimulus
        int unsigned phase_sizes[10];
        int          n_items;
        i_rst_n      <= 1'b0;
        i_valid      <= 1'b0;
        i_data       <= '0;
        i_cfg_we     <= 1'b0;
        i_cfg_wdata  <= '0;
        typed_en     <= 1'b0;
        typed_result <= '0;
        build_directed_rows();
        // sizes for the random phases, extremes included; one picked at random
        phase_sizes = '{4096, 64, 65, 1, 8191, 300, 0, 0, 128, 4096};
        phase_sizes[7] = $urandom_range(2, 4095);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[n]) begin
            if (directed_rows[n].is_size_write)
                write_size(directed_rows[n].size_value);
            else
                send_item(directed_rows[n].req, directed_rows[n].typed,
                          directed_rows[n].answer);
        end

        // random phases, each on a freshly cleared map
        foreach (phase_sizes[p]) begin
            write_size(SIZE_W'(phase_sizes[p]));
            quiet_phase = (p == 2 || p == 5);
            n_items     = (cur_size == 0) ? 15 : 48;
            repeat (n_items) send_item(random_request(cur_size), 1'b0, '0);
        end
        quiet_phase = 1'b0;
        i_valid <= 1'b0;

        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
        if (errors == 0)
            $display("allocation_bitmap_range_engine_top regression: pass");
        else
            $display("allocation_bitmap_range_engine_top regression: fail");
        $finish;
    end

    // ---------------------------------------------------------------
    // result side: random stalls, plus one long hold-off so the block
    // fills its output and skid registers and drops o_ready
    // ---------------------------------------------------------------
    initial begin : result_sink
        int stall;
        bit held;
        held = 1'b0;
        i_ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (!held && results_taken >= 150) begin
                held = 1'b1;
                i_ready <= 1'b0;
                repeat (600) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            stall = pick_gap();
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
        end
    end

    // overall limit, far beyond the slowest correct run
    initial begin : watchdog
        #10_000_000;
        $display("allocation_bitmap_range_engine_top regression: fail");
        $finish;
    end

endmodule
